/* design/bam_pkg.sv */
// Package: shared types and constants for the button autorepeat message block.
`default_nettype none
package bam_pkg;

    localparam int unsigned NumRegs  = 7;
    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 16;

    // register indexes
    localparam logic [CfgIdxW-1:0] RegDebounce   = 3'd0;
    localparam logic [CfgIdxW-1:0] RegHold       = 3'd1;
    localparam logic [CfgIdxW-1:0] RegRepStart   = 3'd2;
    localparam logic [CfgIdxW-1:0] RegSlowPeriod = 3'd3;
    localparam logic [CfgIdxW-1:0] RegFastAfter  = 3'd4;
    localparam logic [CfgIdxW-1:0] RegFastPeriod = 3'd5;
    localparam logic [CfgIdxW-1:0] RegMenuPeriod = 3'd6;

    // pressed codes
    localparam logic [2:0] CodeMenu = 3'd1;
    localparam logic [2:0] CodeDown = 3'd2;
    localparam logic [2:0] CodeUp   = 3'd4;
    localparam logic [2:0] CodeMute = 3'd6;

    // message constants
    localparam logic [10:0] IdMenu    = 11'h122;
    localparam logic [10:0] IdVolume  = 11'h21F;
    localparam logic [3:0]  LenMenu   = 4'd8;
    localparam logic [3:0]  LenVolume = 4'd3;
    localparam logic [7:0]  CmdMenu   = 8'h02;
    localparam logic [7:0]  CmdDown   = 8'h04;
    localparam logic [7:0]  CmdUp     = 8'h08;
    localparam logic [7:0]  CmdMute   = 8'h0C;
    localparam logic [7:0]  MenuByte5 = 8'hFF;

    typedef struct packed {
        logic [15:0] debounce;
        logic [15:0] hold;
        logic [15:0] rep_start;
        logic [15:0] slow_period;
        logic [15:0] fast_after;
        logic [15:0] fast_period;
        logic [15:0] menu_period;
    } t_cfg;

    typedef struct packed {
        logic [31:0] now_ms;
        logic        menu_level;
        logic        down_level;
        logic        up_level;
        logic [7:0]  scroll_value;
    } t_item;

    typedef struct packed {
        logic [31:0] lockout_start;
        logic [2:0]  previous_code;
        logic [31:0] press_start;
        logic [31:0] last_send;
    } t_state;

    typedef struct packed {
        logic [10:0] msg_id;
        logic [3:0]  msg_length;
        logic [7:0]  byte0;
        logic [7:0]  byte1;
        logic [7:0]  byte5;
    } t_msg;

endpackage
`default_nettype wire

/* design/bam_cfg_regs.sv */
// Configuration register file with reset defaults.
`default_nettype none
module bam_cfg_regs
    import bam_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_wr_en,
    input  wire logic [CfgIdxW-1:0]  i_wr_index,
    input  wire logic [CfgDataW-1:0] i_wr_data,
    output t_cfg                     o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce    <= 16'd50;
            r_cfg.hold        <= 16'd100;
            r_cfg.rep_start   <= 16'd800;
            r_cfg.slow_period <= 16'd600;
            r_cfg.fast_after  <= 16'd2000;
            r_cfg.fast_period <= 16'd350;
            r_cfg.menu_period <= 16'd800;
        end else if (i_wr_en) begin
            case (i_wr_index)
                RegDebounce:   r_cfg.debounce    <= i_wr_data;
                RegHold:       r_cfg.hold        <= i_wr_data;
                RegRepStart:   r_cfg.rep_start   <= i_wr_data;
                RegSlowPeriod: r_cfg.slow_period <= i_wr_data;
                RegFastAfter:  r_cfg.fast_after  <= i_wr_data;
                RegFastPeriod: r_cfg.fast_period <= i_wr_data;
                RegMenuPeriod: r_cfg.menu_period <= i_wr_data;
                default: ; // unused index, write dropped
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

/* design/bam_step.sv */
// Per-sample decision logic: lockout, hold timing, autorepeat and message build.
`default_nettype none
module bam_step
    import bam_pkg::*;
(
    input  wire t_cfg   i_cfg,
    input  wire t_state i_state,
    input  wire t_item  i_item,
    output t_state      o_state,
    output logic        o_send,
    output t_msg        o_msg
);

    logic [31:0] lock_age;
    logic [31:0] press_start;
    logic [31:0] last_send;
    logic [31:0] hold;
    logic [31:0] since;
    logic [2:0]  code;
    logic        changed;
    logic        fresh;
    logic        held;
    logic        repeat_ok;
    logic        slow;
    logic        fast;

    always_comb begin
        lock_age = i_item.now_ms - i_state.lockout_start;
        code     = {~i_item.up_level, ~i_item.down_level, ~i_item.menu_level};
        changed  = (code != i_state.previous_code);

        press_start = changed ? i_item.now_ms : i_state.press_start;
        last_send   = changed ? 32'd0 : i_state.last_send;

        hold  = i_item.now_ms - press_start;
        since = i_item.now_ms - last_send;
        fresh = (last_send == 32'd0);
        held  = (hold > {16'd0, i_cfg.hold});
        repeat_ok = (hold > {16'd0, i_cfg.rep_start});
        // exactly at fast_after neither phase applies
        slow = (hold < {16'd0, i_cfg.fast_after}) && (since > {16'd0, i_cfg.slow_period});
        fast = (hold > {16'd0, i_cfg.fast_after}) && (since > {16'd0, i_cfg.fast_period});

        o_send = 1'b0;
        o_msg  = '0;
        o_state.lockout_start = i_state.lockout_start;
        o_state.previous_code = code;
        o_state.press_start   = press_start;
        o_state.last_send     = last_send;

        if (held) begin
            case (code)
                CodeMenu: begin
                    o_send = fresh || (repeat_ok && (since > {16'd0, i_cfg.menu_period}));
                    o_msg.msg_id     = IdMenu;
                    o_msg.msg_length = LenMenu;
                    o_msg.byte0      = CmdMenu;
                    o_msg.byte5      = MenuByte5;
                end
                CodeDown, CodeUp: begin
                    o_send = fresh || (repeat_ok && (slow || fast));
                    o_msg.msg_id     = IdVolume;
                    o_msg.msg_length = LenVolume;
                    o_msg.byte0      = (code == CodeDown) ? CmdDown : CmdUp;
                    o_msg.byte1      = i_item.scroll_value;
                end
                CodeMute: begin
                    o_send = fresh;
                    o_msg.msg_id     = IdVolume;
                    o_msg.msg_length = LenVolume;
                    o_msg.byte0      = CmdMute;
                    o_msg.byte1      = i_item.scroll_value;
                end
                default: begin
                    o_state.lockout_start = i_item.now_ms;
                end
            endcase
            if (o_send) begin
                o_state.lockout_start = i_item.now_ms;
                o_state.last_send     = i_item.now_ms;
            end
        end

        // lockout still running: sample ignored, state untouched
        if (lock_age <= {16'd0, i_cfg.debounce}) begin
            o_send  = 1'b0;
            o_state = i_state;
        end
    end

endmodule
`default_nettype wire

/* design/button_autorepeat_message_gen.sv */
// Top level: button sampler with hold delay and autorepeat, emitting bus messages.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_now_ms, i_*_level, i_scroll_value
//  out     | output    | o_out_valid / i_out_ready | o_msg_id, o_msg_length, o_byte0..7
//  cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One item per cycle sustained while no result is stalled. An item is captured in the
// input register and evaluated against the timing state in a single pass; a result that
// sends lands in the output register. The state update loop closes through the state
// register alone, which is what allows a new item every cycle.
// Synchronous active-low reset restores the register defaults and clears all state.
// A stalled result holds the output register; the input register then holds too,
// so at most one item waits ahead of the result. Config writes are always ready.
`default_nettype none
module button_autorepeat_message_gen
    import bam_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic [31:0]         i_now_ms,
    input  wire logic                i_menu_level,
    input  wire logic                i_down_level,
    input  wire logic                i_up_level,
    input  wire logic [7:0]          i_scroll_value,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic [10:0]              o_msg_id,
    output logic [3:0]               o_msg_length,
    output logic [7:0]               o_byte0,
    output logic [7:0]               o_byte1,
    output logic [7:0]               o_byte2,
    output logic [7:0]               o_byte3,
    output logic [7:0]               o_byte4,
    output logic [7:0]               o_byte5,
    output logic [7:0]               o_byte6,
    output logic [7:0]               o_byte7,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [CfgIdxW-1:0]  i_cfg_index,
    input  wire logic [CfgDataW-1:0] i_cfg_data
);

    t_cfg   cfg;
    t_state r_state;
    t_state n_state;
    t_item  r_in;
    logic   r_in_valid;
    logic   r_out_valid;
    t_msg   r_msg;
    t_msg   n_msg;
    logic   n_send;
    logic   advance;

    assign o_cfg_ready = 1'b1;

    bam_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    // input stage moves whenever the result slot is free or being drained
    assign advance    = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in.now_ms       <= i_now_ms;
            r_in.menu_level   <= i_menu_level;
            r_in.down_level   <= i_down_level;
            r_in.up_level     <= i_up_level;
            r_in.scroll_value <= i_scroll_value;
        end
    end

    bam_step u_step (
        .i_cfg   (cfg),
        .i_state (r_state),
        .i_item  (r_in),
        .o_state (n_state),
        .o_send  (n_send),
        .o_msg   (n_msg)
    );

    // timing state commits as the item leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid && n_send;
            if (r_in_valid) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid && n_send) begin
            r_msg <= n_msg;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_msg_id     = r_msg.msg_id;
    assign o_msg_length = r_msg.msg_length;
    assign o_byte0      = r_msg.byte0;
    assign o_byte1      = r_msg.byte1;
    assign o_byte2      = 8'd0;
    assign o_byte3      = 8'd0;
    assign o_byte4      = 8'd0;
    assign o_byte5      = r_msg.byte5;
    assign o_byte6      = 8'd0;
    assign o_byte7      = 8'd0;

    // a send stamps both the lockout and the last send time with the item's time
    a_send_stamps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_valid && n_send) |=>
            (r_state.lockout_start == $past(r_in.now_ms)) &&
            (r_state.last_send == $past(r_in.now_ms)))
        else $error("send did not stamp lockout and last send");

    // menu results always carry the 8-byte layout
    a_menu_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_msg_id == IdMenu)) |->
            ((o_msg_length == LenMenu) && (o_byte0 == CmdMenu) && (o_byte5 == MenuByte5)))
        else $error("menu message malformed");

    // volume results carry a 3-byte length and a volume command
    a_vol_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_msg_id == IdVolume)) |->
            ((o_msg_length == LenVolume) && (o_byte5 == 8'd0) &&
             ((o_byte0 == CmdDown) || (o_byte0 == CmdUp) || (o_byte0 == CmdMute))))
        else $error("volume message malformed");

    // no result is presented right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule
`default_nettype wire

/* dv/testbench.sv */
// Testbench for button_autorepeat_message_gen: directed table, random press runs, scoreboard.
`timescale 1ns / 100ps
module testbench;
    import bam_pkg::*;

    // Pin patterns {menu, down, up}; pins are active low.
    localparam logic [2:0] Released  = 3'b111;
    localparam logic [2:0] PressMenu = 3'b011;
    localparam logic [2:0] PressDown = 3'b101;
    localparam logic [2:0] PressUp   = 3'b110;
    localparam logic [2:0] PressMute = 3'b100;
    localparam logic [2:0] PressAll  = 3'b000;

    // Index past the register file; the block must drop writes to it.
    localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;

    // Power-up register values, index 0 in the low slot.
    localparam logic [NumRegs-1:0][15:0] RegDefaults = {
        16'd800, 16'd350, 16'd2000, 16'd600, 16'd800, 16'd100, 16'd50
    };

    localparam int unsigned QuietLimit   = 3000; // cycles with no handshake at all
    localparam int unsigned SettleCycles = 6;    // input and output registers plus margin
    localparam int unsigned PhaseTarget  = 140;  // items per random phase

    // One bus message; data[i] is byte i.
    typedef struct packed {
        logic [10:0]     id;
        logic [3:0]      len;
        logic [7:0][7:0] data;
    } t_bus_msg;

    // How a directed row gets its expectation.
    typedef enum logic [1:0] {EXP_PREDICT, EXP_NONE, EXP_MSG} t_exp_kind;

    typedef enum logic [2:0] {CFG_DEFAULT, CFG_ZERO, CFG_MAX, CFG_SMALL, CFG_WIDE} t_reg_set;

    typedef struct packed {
        logic [31:0] now_ms;
        logic [2:0]  levels;
        logic [7:0]  scroll;
        t_exp_kind   kind;
        logic [10:0] id;
        logic [3:0]  len;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  b5;
    } t_row;

    // Clock, reset and every block input start at known values.
    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_in_valid     = 1'b0;
    logic [31:0]         i_now_ms       = '0;
    logic                i_menu_level   = 1'b1;
    logic                i_down_level   = 1'b1;
    logic                i_up_level     = 1'b1;
    logic [7:0]          i_scroll_value = '0;
    logic                i_out_ready    = 1'b0;
    logic                i_cfg_valid    = 1'b0;
    logic [CfgIdxW-1:0]  i_cfg_index    = '0;
    logic [CfgDataW-1:0] i_cfg_data     = '0;
    logic                o_in_ready;
    logic                o_out_valid;
    logic                o_cfg_ready;
    logic [10:0]         o_msg_id;
    logic [3:0]          o_msg_length;
    logic [7:0]          o_byte0, o_byte1, o_byte2, o_byte3;
    logic [7:0]          o_byte4, o_byte5, o_byte6, o_byte7;

    button_autorepeat_message_gen DUT (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Mirror of the block's timing state and registers; the timing state starts at zero.
    logic [15:0] cfg_regs [NumRegs];
    logic [31:0] lockout_ms   = '0;
    logic [2:0]  prev_code    = '0;
    logic [31:0] press_ms     = '0;
    logic [31:0] last_send_ms = '0;  // zero doubles as "nothing sent yet"

    t_bus_msg    pending_msgs [$];   // expected messages, oldest first
    int unsigned mismatch_cnt  = 0;
    int unsigned quiet_cycles  = 0;
    int unsigned send_idle_pct = 10;
    int unsigned recv_idle_pct = 54;
    logic [31:0] sample_ms     = '0; // running sample time of the random part
    t_bus_msg    seen_msg, want_msg;

    // Directed table. Lockout and hold limits are hit one ms either side,
    // then every message type, the exact fast-phase boundary, the idle codes,
    // and a send at time zero that still reads as never sent.
    t_row dir_rows [25] = '{
        '{32'd0,         Released,  8'h00, EXP_NONE,    11'h0, 4'h0, 8'h00, 8'h00, 8'h00},
        '{32'd50,        Released,  8'h00, EXP_NONE,    11'h0, 4'h0, 8'h00, 8'h00, 8'h00},
        '{32'd51,        PressMenu, 8'h00, EXP_NONE,    11'h0, 4'h0, 8'h00, 8'h00, 8'h00},
        '{32'd151,       PressMenu, 8'h00, EXP_NONE,    11'h0, 4'h0, 8'h00, 8'h00, 8'h00},
        '{32'd152,       PressMenu, 8'h00, EXP_MSG, IdMenu, LenMenu, CmdMenu, 8'h00, MenuByte5},
        '{32'd202,       PressMenu, 8'h00, EXP_NONE,    11'h0, 4'h0, 8'h00, 8'h00, 8'h00},
        '{32'd952,       PressMenu, 8'h00, EXP_NONE,    11'h0, 4'h0, 8'h00, 8'h00, 8'h00},
        '{32'd953,       PressMenu, 8'h00, EXP_MSG, IdMenu, LenMenu, CmdMenu, 8'h00, MenuByte5},
        '{32'd1004,      PressDown, 8'hFF, EXP_NONE,    11'h0, 4'h0, 8'h00, 8'h00, 8'h00},
        '{32'd1105,      PressDown, 8'hFF, EXP_MSG, IdVolume, LenVolume, CmdDown, 8'hFF, 8'h00},
        '{32'd1905,      PressDown, 8'h00, EXP_MSG, IdVolume, LenVolume, CmdDown, 8'h00, 8'h00},
        '{32'd3004,      PressDown, 8'h5A, EXP_NONE,    11'h0, 4'h0, 8'h00, 8'h00, 8'h00},
        '{32'd3005,      PressDown, 8'h81, EXP_MSG, IdVolume, LenVolume, CmdDown, 8'h81, 8'h00},
        '{32'd3356,      PressDown, 8'h7E, EXP_MSG, IdVolume, LenVolume, CmdDown, 8'h7E, 8'h00},
        '{32'd3407,      PressUp,   8'h00, EXP_NONE,    11'h0, 4'h0, 8'h00, 8'h00, 8'h00},
        '{32'd3508,      PressUp,   8'h5A, EXP_MSG, IdVolume, LenVolume, CmdUp, 8'h5A, 8'h00},
        '{32'd3559,      PressMute, 8'h00, EXP_NONE,    11'h0, 4'h0, 8'h00, 8'h00, 8'h00},
        '{32'd3660,      PressMute, 8'h3C, EXP_MSG, IdVolume, LenVolume, CmdMute, 8'h3C, 8'h00},
        '{32'd9999,      PressMute, 8'h11, EXP_PREDICT, 11'h0, 4'h0, 8'h00, 8'h00, 8'h00},
        '{32'd10050,     PressAll,  8'h00, EXP_NONE,    11'h0, 4'h0, 8'h00, 8'h00, 8'h00},
        '{32'd10151,     PressAll,  8'h00, EXP_PREDICT, 11'h0, 4'h0, 8'h00, 8'h00, 8'h00},
        '{32'hFFFF_FF00, PressMenu, 8'h00, EXP_NONE,    11'h0, 4'h0, 8'h00, 8'h00, 8'h00},
        '{32'h0,         PressMenu, 8'h00, EXP_MSG, IdMenu, LenMenu, CmdMenu, 8'h00, MenuByte5},
        '{32'd51,        PressMenu, 8'h00, EXP_MSG, IdMenu, LenMenu, CmdMenu, 8'h00, MenuByte5},
        '{32'hFFFF_FFFF, Released,  8'h00, EXP_PREDICT, 11'h0, 4'h0, 8'h00, 8'h00, 8'h00}
    };

    // Fixed message layout for a pressed code.
    function automatic t_bus_msg form_msg(input logic [2:0] code, input logic [7:0] scroll);
        t_bus_msg m;
        m = '0;
        if (code == CodeMenu) begin
            m.id      = IdMenu;
            m.len     = LenMenu;
            m.data[0] = CmdMenu;
            m.data[5] = MenuByte5;
        end else begin
            m.id      = IdVolume;
            m.len     = LenVolume;
            m.data[1] = scroll;
            case (code)
                CodeDown: m.data[0] = CmdDown;
                CodeUp:   m.data[0] = CmdUp;
                default:  m.data[0] = CmdMute;
            endcase
        end
        return m;
    endfunction

    // Advance the timing state by one sample. Returns 1 when a message goes out;
    // a sample inside the lockout window leaves the state alone.
    function automatic bit predict_msg(input t_item it, output t_bus_msg msg);
        logic [31:0] since_lock, hold_ms, since_send;
        logic [2:0]  code;
        bit          fresh, slow_ok, fast_ok, fire;
        msg        = '0;
        fire       = 1'b0;
        since_lock = it.now_ms - lockout_ms;   // wraps modulo 2^32
        if (since_lock <= cfg_regs[RegDebounce])
            return 1'b0;
        code = {~it.up_level, ~it.down_level, ~it.menu_level};
        if (code != prev_code) begin
            press_ms     = it.now_ms;
            last_send_ms = '0;
        end
        hold_ms    = it.now_ms - press_ms;
        since_send = it.now_ms - last_send_ms;
        fresh      = (last_send_ms == '0);
        if (hold_ms > cfg_regs[RegHold]) begin
            case (code)
                CodeMenu: fire = fresh || (hold_ms > cfg_regs[RegRepStart] &&
                                           since_send > cfg_regs[RegMenuPeriod]);
                CodeDown, CodeUp: begin
                    // hold exactly at fast_after is in neither phase
                    slow_ok = hold_ms < cfg_regs[RegFastAfter] &&
                              since_send > cfg_regs[RegSlowPeriod];
                    fast_ok = hold_ms > cfg_regs[RegFastAfter] &&
                              since_send > cfg_regs[RegFastPeriod];
                    fire = fresh || (hold_ms > cfg_regs[RegRepStart] && (slow_ok || fast_ok));
                end
                CodeMute: fire = fresh;
                default:  lockout_ms = it.now_ms;   // idle codes only renew the lockout
            endcase
            if (fire) begin
                msg          = form_msg(code, it.scroll_value);
                lockout_ms   = it.now_ms;
                last_send_ms = it.now_ms;
            end
        end
        prev_code = code;
        return fire;
    endfunction

    // Offer one sample, hold it until taken, then queue what it should produce.
    // Valid is only dropped for a random gap, never lowered and raised in one step.
    task automatic push_item(input t_item it, input t_exp_kind kind,
                             input t_bus_msg listed);
        t_bus_msg pred;
        bit       fire;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_now_ms       <= it.now_ms;
        i_menu_level   <= it.menu_level;
        i_down_level   <= it.down_level;
        i_up_level     <= it.up_level;
        i_scroll_value <= it.scroll_value;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        // The mirror state always advances, even when the table fixes the answer.
        fire = predict_msg(it, pred);
        case (kind)
            EXP_PREDICT: if (fire) pending_msgs.push_back(pred);
            EXP_MSG:     pending_msgs.push_back(listed);
            default:     ;
        endcase
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx < NumRegs)
            cfg_regs[idx] = val;
    endtask

    // Rewrite the whole register file, then poke the unused index.
    task automatic reprogram(input t_reg_set set);
        logic [15:0] val;
        for (int k = 0; k < NumRegs; k++) begin
            case (set)
                CFG_ZERO:  val = '0;
                CFG_MAX:   val = '1;
                CFG_SMALL: val = 16'($urandom_range(0, 600));
                CFG_WIDE:  val = 16'($urandom());
                default:   val = RegDefaults[k];
            endcase
            write_reg(CfgIdxW'(k), val);
        end
        write_reg(RegUnused, 16'($urandom()));
        i_cfg_valid <= 1'b0;
    endtask

    // Wait for every expected message, then let in-flight silent items retire.
    task automatic settle();
        while (pending_msgs.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    // Random part: mostly steady presses with monotonic time so holds reach
    // the repeat and fast phases, plus short noisy bursts with time jumps,
    // wrap-around and random pin patterns. Step size follows the register scale.
    task automatic run_phase(input int unsigned target);
        int unsigned counted, run_len, span, top;
        logic [2:0]  levels;
        bit          noisy;
        t_item       it;
        t_bus_msg    unused_msg;
        counted    = 0;
        top        = 0;
        unused_msg = '0;
        for (int k = 0; k < NumRegs; k++)
            if (cfg_regs[k] > top) top = cfg_regs[k];
        span = top / 8 + 4;
        while (counted < target) begin
            noisy   = ($urandom_range(99) < 15);
            run_len = noisy ? $urandom_range(1, 4) : $urandom_range(3, 40);
            case ($urandom_range(9))
                0, 1:    levels = PressMenu;
                2, 3:    levels = PressDown;
                4, 5:    levels = PressUp;
                6, 7:    levels = PressMute;
                default: levels = 3'($urandom());
            endcase
            repeat (run_len) begin
                if (noisy && $urandom_range(1) == 1)
                    sample_ms = ($urandom_range(3) == 0) ?
                                32'hFFFF_FFFF - $urandom_range(0, 4 * span) : $urandom();
                else
                    sample_ms = sample_ms + $urandom_range(0, span);
                it.now_ms = sample_ms;
                if (noisy || $urandom_range(99) < 5)
                    {it.menu_level, it.down_level, it.up_level} = 3'($urandom());
                else
                    {it.menu_level, it.down_level, it.up_level} = levels;
                it.scroll_value = 8'($urandom());
                push_item(it, EXP_PREDICT, unused_msg);
                counted++;
            end
        end
    endtask

    // Output side: random back-pressure, in-order compare against the queue.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen_msg = {o_msg_id, o_msg_length, o_byte7, o_byte6, o_byte5, o_byte4,
                        o_byte3, o_byte2, o_byte1, o_byte0};
            if (pending_msgs.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("%0t: unexpected message id=%h len=%h data=%h",
                             $realtime, seen_msg.id, seen_msg.len, seen_msg.data);
            end else begin
                want_msg = pending_msgs.pop_front();
                if (seen_msg.id !== want_msg.id || seen_msg.len !== want_msg.len ||
                    seen_msg.data !== want_msg.data) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("%0t: message mismatch: expected id=%h len=%h data=%h, %s",
                                 $realtime, want_msg.id, want_msg.len, want_msg.data,
                                 $sformatf("got id=%h len=%h data=%h", seen_msg.id,
                                           seen_msg.len, seen_msg.data));
                end
            end
        end
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: any handshake on any channel counts as progress.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QuietLimit) begin
            $display("button_autorepeat_message_gen verification failed");
            $finish;
        end
    end

    initial begin
        t_item    it;
        t_bus_msg listed;
        t_reg_set set;
        for (int k = 0; k < NumRegs; k++)
            cfg_regs[k] = RegDefaults[k];

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at power-up register values, sender lightly idle.
        foreach (dir_rows[r]) begin
            it.now_ms       = dir_rows[r].now_ms;
            {it.menu_level, it.down_level, it.up_level} = dir_rows[r].levels;
            it.scroll_value = dir_rows[r].scroll;
            listed          = '0;
            listed.id       = dir_rows[r].id;
            listed.len      = dir_rows[r].len;
            listed.data[0]  = dir_rows[r].b0;
            listed.data[1]  = dir_rows[r].b1;
            listed.data[5]  = dir_rows[r].b5;
            push_item(it, dir_rows[r].kind, listed);
        end
        i_in_valid <= 1'b0;
        settle();

        // Random phases; registers change only while the pipeline is empty.
        for (int p = 0; p < 6; p++) begin
            if (p == 2) begin
                send_idle_pct = 54;
                recv_idle_pct = 10;
            end else if (p == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (p)
                0, 2:    set = CFG_SMALL;
                1:       set = CFG_ZERO;
                3:       set = CFG_MAX;
                4:       set = CFG_WIDE;
                default: set = CFG_DEFAULT;
            endcase
            reprogram(set);
            run_phase(PhaseTarget);
            i_in_valid <= 1'b0;
            settle();
        end

        if (mismatch_cnt == 0)
            $display("button_autorepeat_message_gen verification clean");
        else
            $display("button_autorepeat_message_gen verification failed");
        $finish;
    end

endmodule
